### rtl/dafp_pkg.sv
// ----------------------------------------------------------------------------
// dafp_pkg
// Shared widths, beat types and CORDIC arctangent table for the dihedral
// angle unit.
// ----------------------------------------------------------------------------
package dafp_pkg;

    localparam int C_COORD_W   = 32;
    localparam int C_FRAC      = 16;
    localparam int C_TOR_W     = C_FRAC + 3;

    localparam int C_BOND_BITS = 31;
    localparam int C_NORM_BITS = 30;
    localparam int C_BM_W      = C_COORD_W + 1;
    localparam int C_BS_W      = C_BOND_BITS + 1;
    localparam int C_NM_W      = 2 * C_BS_W;
    localparam int C_MS_W      = C_NORM_BITS + 1;
    localparam int C_DP_W      = 2 * C_MS_W;
    localparam int C_X_W       = C_DP_W + 1;
    localparam int C_TP_W      = C_BS_W + C_MS_W;
    localparam int C_T_W       = 6;

    localparam int C_SQRT_N    = 32;
    localparam int C_SQRT_IW   = $clog2(C_SQRT_N);
    localparam int C_CORDIC_N  = 48;
    localparam int C_CORDIC_W  = 48;
    localparam int C_CORD_IW   = $clog2(C_CORDIC_N);
    localparam int C_CX_W      = C_CORDIC_W + 4;

    localparam logic [63:0] C_PI   = 64'hC90FDAA22168C235;
    localparam logic [63:0] C_QPI  = 64'h3243F6A8885A308D;
    localparam logic [63:0] C_PI_Q = (C_PI + (64'(1) << (61 - C_FRAC))) >> (62 - C_FRAC);

    typedef logic [3:0][2:0][C_COORD_W-1:0] t_pts;

    typedef struct packed {
        logic                    deg;
        logic                    tneg;
        logic signed [C_X_W-1:0] x;
        logic [C_T_W-1:0]        tsh;
    } t_sqrt_side;

    typedef struct packed {
        logic        valid;
        logic [63:0] v;
        logic [63:0] r;
        t_sqrt_side  side;
    } t_sqrt;

    typedef struct packed {
        logic deg;
        logic tneg;
        logic xneg;
        logic yzero;
    } t_cord_side;

    typedef struct packed {
        logic                     valid;
        logic signed [C_CX_W-1:0] cx;
        logic signed [C_CX_W-1:0] cy;
        logic [63:0]              z;
        t_cord_side               side;
    } t_cord;

    typedef logic [63:0] t_atan_tab [C_CORDIC_N];

    // floor(2^e / d) by shift-subtract, elaboration only
    function automatic logic [63:0] f_pow2_div(input int e, input int d);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        num = 64'(1) << e;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(d)) begin
                rem  = rem - 64'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q62 from the alternating series
    function automatic t_atan_tab f_atan_tab();
        t_atan_tab   t;
        logic [63:0] sum;
        int          e;
        t[0] = C_QPI;
        for (int i = 1; i < C_CORDIC_N; i++) begin
            sum = '0;
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    if ((k & 1) != 0) begin
                        sum = sum - f_pow2_div(e, 2 * k + 1);
                    end else begin
                        sum = sum + f_pow2_div(e, 2 * k + 1);
                    end
                end
            end
            t[i] = sum;
        end
        return t;
    endfunction

    localparam t_atan_tab C_ATAN = f_atan_tab();

    function automatic logic [6:0] f_bitlen(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int b = 0; b < 64; b++) begin
            if (v[b]) begin
                n = 7'(b + 1);
            end
        end
        return n;
    endfunction

endpackage

### rtl/dafp_if.sv
// ----------------------------------------------------------------------------
// dafp_if
// Valid/ready channels: four-point input beat and torsion result beat.
// ----------------------------------------------------------------------------
interface dafp_pt_if import dafp_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [C_COORD_W-1:0] p1_x;
    logic signed [C_COORD_W-1:0] p1_y;
    logic signed [C_COORD_W-1:0] p1_z;
    logic signed [C_COORD_W-1:0] p2_x;
    logic signed [C_COORD_W-1:0] p2_y;
    logic signed [C_COORD_W-1:0] p2_z;
    logic signed [C_COORD_W-1:0] p3_x;
    logic signed [C_COORD_W-1:0] p3_y;
    logic signed [C_COORD_W-1:0] p3_z;
    logic signed [C_COORD_W-1:0] p4_x;
    logic signed [C_COORD_W-1:0] p4_y;
    logic signed [C_COORD_W-1:0] p4_z;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
    modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

interface dafp_ang_if import dafp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [C_TOR_W-1:0] torsion;
    logic                      degenerate;

    modport source (output valid, torsion, degenerate, input ready);
    modport sink   (input valid, torsion, degenerate, output ready);
endinterface

### rtl/dafp_geom.sv
// ----------------------------------------------------------------------------
// dafp_geom
// 13-stage front end: bonds, normals, block scaling, normal dot/cross,
// sum of squares and sign product feeding the square-root row.
// ----------------------------------------------------------------------------
module dafp_geom import dafp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pts  i_pts,
    output t_sqrt o_sq
);

    logic [12:0] r_v;

    logic signed [C_COORD_W-1:0] w_p [4][3];

    logic signed [C_BM_W-1:0]   r_b   [3][3];
    logic [C_BM_W-1:0]          r_bm  [3][3];
    logic                       r_bng [3][3];
    logic [C_BM_W-1:0]          r_bor [3];
    logic signed [C_BS_W-1:0]   r_bs  [3][3];
    logic signed [C_NM_W-1:0]   r_pr  [2][6];
    logic signed [C_NM_W-1:0]   r_n   [2][3];
    logic [C_NM_W-1:0]          r_nm  [2][3];
    logic                       r_nng [2][3];
    logic [C_NM_W-1:0]          r_nor [2];
    logic signed [C_MS_W-1:0]   r_m   [2][3];
    logic signed [C_DP_W-1:0]   r_dp  [3];
    logic signed [C_DP_W-1:0]   r_cp  [6];
    logic signed [C_DP_W-1:0]   r_c   [3];
    logic [C_DP_W-1:0]          r_cm  [3];
    logic                       r_cng [3];
    logic [C_DP_W-1:0]          r_cor;
    logic [C_NORM_BITS-1:0]     r_ca  [3];
    logic signed [C_MS_W-1:0]   r_cs  [3];
    logic [2*C_NORM_BITS-1:0]   r_sqp [3];
    logic signed [C_TP_W-1:0]   r_tp  [3];

    logic signed [C_BS_W-1:0]   r_b2  [4:12][3];
    logic                       r_deg [6:12];
    logic signed [C_X_W-1:0]    r_x   [9:12];
    logic [C_T_W-1:0]           r_t   [11:12];
    t_sqrt                      r_o;

    logic [6:0]                 w_bsh [3];
    logic [6:0]                 w_nsh [2];
    logic [6:0]                 w_csh;
    logic [C_BS_W-1:0]          w_bsv [3][3];
    logic [C_MS_W-1:0]          w_msv [2][3];
    logic [C_MS_W-1:0]          w_csv [3];
    logic [C_BM_W-1:0]          w_bor [3];
    logic [C_NM_W-1:0]          w_nor [2];
    logic [C_DP_W-1:0]          w_cor;
    logic [C_BM_W-1:0]          w_bm  [3][3];
    logic [C_NM_W-1:0]          w_nm  [2][3];
    logic [C_DP_W-1:0]          w_cm  [3];
    logic [6:0]                 w_len;
    logic [2*C_NORM_BITS+1:0]   w_sq;
    logic signed [C_TP_W+1:0]   w_trip;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_p[j][k] = $signed(i_pts[j][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[11:0], i_valid};
        end
    end

    // magnitudes, OR-reduction and block shifts
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_bor[j] = '0;
            for (int k = 0; k < 3; k++) begin
                w_bm[j][k] = r_b[j][k][C_BM_W-1] ? C_BM_W'(-r_b[j][k]) : C_BM_W'(r_b[j][k]);
                w_bor[j]   = w_bor[j] | w_bm[j][k];
            end
            w_len    = f_bitlen(64'(r_bor[j]));
            w_bsh[j] = (w_len > 7'(C_BOND_BITS)) ? w_len - 7'(C_BOND_BITS) : 7'd0;
            for (int k = 0; k < 3; k++) begin
                w_bsv[j][k] = C_BS_W'(r_bm[j][k] >> w_bsh[j]);
            end
        end
        for (int a = 0; a < 2; a++) begin
            w_nor[a] = '0;
            for (int k = 0; k < 3; k++) begin
                w_nm[a][k] = r_n[a][k][C_NM_W-1] ? C_NM_W'(-r_n[a][k]) : C_NM_W'(r_n[a][k]);
                w_nor[a]   = w_nor[a] | w_nm[a][k];
            end
            w_len    = f_bitlen(64'(r_nor[a]));
            w_nsh[a] = (w_len > 7'(C_NORM_BITS)) ? w_len - 7'(C_NORM_BITS) : 7'd0;
            for (int k = 0; k < 3; k++) begin
                w_msv[a][k] = C_MS_W'(r_nm[a][k] >> w_nsh[a]);
            end
        end
        w_cor = '0;
        for (int k = 0; k < 3; k++) begin
            w_cm[k] = r_c[k][C_DP_W-1] ? C_DP_W'(-r_c[k]) : C_DP_W'(r_c[k]);
            w_cor   = w_cor | w_cm[k];
        end
        w_len = f_bitlen(64'(r_cor));
        w_csh = (w_len > 7'(C_NORM_BITS)) ? w_len - 7'(C_NORM_BITS) : 7'd0;
        for (int k = 0; k < 3; k++) begin
            w_csv[k] = C_MS_W'(r_cm[k] >> w_csh);
        end
        w_sq   = (2*C_NORM_BITS+2)'(r_sqp[0]) + (2*C_NORM_BITS+2)'(r_sqp[1])
               + (2*C_NORM_BITS+2)'(r_sqp[2]);
        w_trip = (C_TP_W+2)'(r_tp[0]) + (C_TP_W+2)'(r_tp[1]) + (C_TP_W+2)'(r_tp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_bor[j] <= w_bor[j];
                for (int k = 0; k < 3; k++) begin
                    r_b[j][k]   <= C_BM_W'(w_p[j+1][k]) - C_BM_W'(w_p[j][k]);
                    r_bm[j][k]  <= w_bm[j][k];
                    r_bng[j][k] <= r_b[j][k][C_BM_W-1];
                    r_bs[j][k]  <= r_bng[j][k] ? -$signed(w_bsv[j][k]) : $signed(w_bsv[j][k]);
                end
            end
            for (int a = 0; a < 2; a++) begin
                r_pr[a][0] <= r_bs[a][1] * r_bs[a+1][2];
                r_pr[a][1] <= r_bs[a][2] * r_bs[a+1][1];
                r_pr[a][2] <= r_bs[a][2] * r_bs[a+1][0];
                r_pr[a][3] <= r_bs[a][0] * r_bs[a+1][2];
                r_pr[a][4] <= r_bs[a][0] * r_bs[a+1][1];
                r_pr[a][5] <= r_bs[a][1] * r_bs[a+1][0];
                r_n[a][0]  <= r_pr[a][0] - r_pr[a][1];
                r_n[a][1]  <= r_pr[a][2] - r_pr[a][3];
                r_n[a][2]  <= r_pr[a][4] - r_pr[a][5];
                r_nor[a]   <= w_nor[a];
                for (int k = 0; k < 3; k++) begin
                    r_nm[a][k]  <= w_nm[a][k];
                    r_nng[a][k] <= r_n[a][k][C_NM_W-1];
                    r_m[a][k]   <= r_nng[a][k] ? -$signed(w_msv[a][k]) : $signed(w_msv[a][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_dp[k]  <= r_m[0][k] * r_m[1][k];
                r_cm[k]  <= w_cm[k];
                r_cng[k] <= r_c[k][C_DP_W-1];
                r_ca[k]  <= C_NORM_BITS'(w_csv[k]);
                r_cs[k]  <= r_cng[k] ? -$signed(w_csv[k]) : $signed(w_csv[k]);
                r_sqp[k] <= r_ca[k] * r_ca[k];
                r_tp[k]  <= r_b2[11][k] * r_cs[k];
            end
            r_cp[0] <= r_m[0][1] * r_m[1][2];
            r_cp[1] <= r_m[0][2] * r_m[1][1];
            r_cp[2] <= r_m[0][2] * r_m[1][0];
            r_cp[3] <= r_m[0][0] * r_m[1][2];
            r_cp[4] <= r_m[0][0] * r_m[1][1];
            r_cp[5] <= r_m[0][1] * r_m[1][0];
            r_c[0]  <= r_cp[0] - r_cp[1];
            r_c[1]  <= r_cp[2] - r_cp[3];
            r_c[2]  <= r_cp[4] - r_cp[5];
            r_cor   <= w_cor;

            r_b2[4] <= r_bs[1];
            for (int s = 5; s <= 12; s++) begin
                r_b2[s] <= r_b2[s-1];
            end
            r_deg[6] <= ((r_n[0][0] == '0) && (r_n[0][1] == '0) && (r_n[0][2] == '0))
                     || ((r_n[1][0] == '0) && (r_n[1][1] == '0) && (r_n[1][2] == '0));
            for (int s = 7; s <= 12; s++) begin
                r_deg[s] <= r_deg[s-1];
            end
            r_x[9]  <= C_X_W'(r_dp[0]) + C_X_W'(r_dp[1]) + C_X_W'(r_dp[2]);
            r_x[10] <= r_x[9];
            r_x[11] <= r_x[10];
            r_x[12] <= r_x[11];
            r_t[11] <= C_T_W'(w_csh);
            r_t[12] <= r_t[11];

            r_o.valid     <= 1'b0;
            r_o.v         <= 64'(w_sq);
            r_o.r         <= '0;
            r_o.side.deg  <= r_deg[12];
            r_o.side.tneg <= w_trip[C_TP_W+1];
            r_o.side.x    <= r_x[12];
            r_o.side.tsh  <= r_t[12];
        end
    end

    always_comb begin
        o_sq       = r_o;
        o_sq.valid = r_v[12];
    end

endmodule

### rtl/dafp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dafp_sqrt_cell
// One root bit of the integer square root; a row of these forms the
// pipelined digit-by-digit root.
// ----------------------------------------------------------------------------
module dafp_sqrt_cell import dafp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [C_SQRT_IW-1:0] i_idx,
    input  t_sqrt                i_d,
    output t_sqrt                o_d
);

    logic [6:0]  w_sh;
    logic [63:0] w_bit;
    logic [63:0] w_trial;
    t_sqrt       n_d;
    t_sqrt       r_d;
    logic        r_vld;

    always_comb begin
        w_sh    = 7'(2 * (C_SQRT_N - 1)) - 7'({i_idx, 1'b0});
        w_bit   = 64'(1) << w_sh;
        w_trial = i_d.r + w_bit;
        n_d     = i_d;
        if (i_d.v >= w_trial) begin
            n_d.v = i_d.v - w_trial;
            n_d.r = (i_d.r >> 1) + w_bit;
        end else begin
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    always_comb begin
        o_d       = r_d;
        o_d.valid = r_vld;
    end

endmodule

### rtl/dafp_cordic_cell.sv
// ----------------------------------------------------------------------------
// dafp_cordic_cell
// One vectoring CORDIC micro-rotation; a row of these drives y to zero
// and accumulates the angle in Q62.
// ----------------------------------------------------------------------------
module dafp_cordic_cell import dafp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [C_CORD_IW-1:0] i_idx,
    input  t_cord                i_d,
    output t_cord                o_d
);

    logic signed [C_CX_W-1:0] w_dx;
    logic signed [C_CX_W-1:0] w_dy;
    logic [63:0]              w_t;
    t_cord                    n_d;
    t_cord                    r_d;
    logic                     r_vld;

    always_comb begin
        w_dx = i_d.cy >>> i_idx;
        w_dy = i_d.cx >>> i_idx;
        w_t  = C_ATAN[i_idx];
        n_d  = i_d;
        if (!i_d.cy[C_CX_W-1]) begin
            n_d.cx = i_d.cx + w_dx;
            n_d.cy = i_d.cy - w_dy;
            n_d.z  = i_d.z + w_t;
        end else begin
            n_d.cx = i_d.cx - w_dx;
            n_d.cy = i_d.cy + w_dy;
            n_d.z  = i_d.z - w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    always_comb begin
        o_d       = r_d;
        o_d.valid = r_vld;
    end

endmodule

### rtl/dihedral_angle_four_points_unit.sv
// ----------------------------------------------------------------------------
// dihedral_angle_four_points_unit
// Signed torsion angle of four Q16.16 points about the middle bond, Q3.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt  : sink channel, one beat carries the twelve point coordinates.
//   o_ang : source channel, one beat carries torsion and degenerate.
//   One result beat per input beat, in order.
//   Pipeline: 13 front-end stages, a 32-cell square-root row, 3 normalize
//   stages, a 48-cell CORDIC row, angle select and the output register.
//   Throughput: one beat per cycle while the pipe advances; every stage is a
//   register, the rows of cells pass one beat to the next cell on each advance.
//   Stall: the whole pipe advances while the output register is empty or
//   being taken; i_pt.ready drops only while a result sits unread.
//   Reset: synchronous, active low; clears all valid bits, the pipe comes
//   out empty and ready.
//   A zero-length plane normal gives degenerate = 1 and torsion = 0.
// ----------------------------------------------------------------------------
module dihedral_angle_four_points_unit import dafp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    dafp_pt_if.sink    i_pt,
    dafp_ang_if.source o_ang
);

    logic  w_adv;
    t_pts  w_pts;
    t_sqrt w_sq [C_SQRT_N+1];
    t_cord w_cd [C_CORDIC_N+1];
    t_sqrt w_s;

    logic        r_p1_v;
    logic [63:0] r_p1_ax;
    logic [63:0] r_p1_y;
    logic [63:0] r_p1_or;
    t_cord_side  r_p1_side;
    logic        r_p2_v;
    logic [63:0] r_p2_ax;
    logic [63:0] r_p2_y;
    logic [6:0]  r_p2_len;
    t_cord_side  r_p2_side;
    logic        r_p3_v;
    t_cord       r_p3;

    logic        r_f1_v;
    logic [63:0] r_f1_ang;
    logic        r_f1_tneg;
    logic        r_f1_deg;

    logic                      r_o_v;
    logic signed [C_TOR_W-1:0] r_o_tor;
    logic                      r_o_deg;

    logic [63:0]        w_y;
    logic [63:0]        w_ax;
    logic [63:0]        w_axn;
    logic [63:0]        w_yn;
    logic [63:0]        w_z;
    logic [63:0]        w_ang;
    logic [63:0]        w_rnd;
    logic [C_TOR_W-1:0] w_q;
    t_cord              w_c;

    assign w_adv      = !r_o_v || o_ang.ready;
    assign i_pt.ready = w_adv;

    assign w_pts[0][0] = i_pt.p1_x;
    assign w_pts[0][1] = i_pt.p1_y;
    assign w_pts[0][2] = i_pt.p1_z;
    assign w_pts[1][0] = i_pt.p2_x;
    assign w_pts[1][1] = i_pt.p2_y;
    assign w_pts[1][2] = i_pt.p2_z;
    assign w_pts[2][0] = i_pt.p3_x;
    assign w_pts[2][1] = i_pt.p3_y;
    assign w_pts[2][2] = i_pt.p3_z;
    assign w_pts[3][0] = i_pt.p4_x;
    assign w_pts[3][1] = i_pt.p4_y;
    assign w_pts[3][2] = i_pt.p4_z;

    dafp_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_pt.valid),
        .i_pts   (w_pts),
        .o_sq    (w_sq[0])
    );

    for (genvar g = 0; g < C_SQRT_N; g++) begin : g_sqrt
        dafp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (C_SQRT_IW'(g)),
            .i_d     (w_sq[g]),
            .o_d     (w_sq[g+1])
        );
    end

    // root back to full scale, then bring |x| and y to 48 bits
    always_comb begin
        w_s  = w_sq[C_SQRT_N];
        w_y  = w_s.r << w_s.side.tsh;
        w_ax = w_s.side.x[C_X_W-1] ? 64'(-w_s.side.x) : 64'(w_s.side.x);
        if (r_p2_len > 7'(C_CORDIC_W)) begin
            w_axn = r_p2_ax >> (r_p2_len - 7'(C_CORDIC_W));
            w_yn  = r_p2_y  >> (r_p2_len - 7'(C_CORDIC_W));
        end else begin
            w_axn = r_p2_ax << (7'(C_CORDIC_W) - r_p2_len);
            w_yn  = r_p2_y  << (7'(C_CORDIC_W) - r_p2_len);
        end
        w_c       = r_p3;
        w_c.valid = r_p3_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (w_adv) begin
            r_p1_v <= w_s.valid;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_f1_v <= w_cd[C_CORDIC_N].valid;
            r_o_v  <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_ax         <= w_ax;
            r_p1_y          <= w_y;
            r_p1_or         <= w_ax | w_y;
            r_p1_side.deg   <= w_s.side.deg;
            r_p1_side.tneg  <= w_s.side.tneg;
            r_p1_side.xneg  <= w_s.side.x[C_X_W-1];
            r_p1_side.yzero <= (w_y == '0);

            r_p2_ax   <= r_p1_ax;
            r_p2_y    <= r_p1_y;
            r_p2_len  <= f_bitlen(r_p1_or);
            r_p2_side <= r_p1_side;

            r_p3.valid <= 1'b0;
            r_p3.cx    <= $signed({{(C_CX_W-C_CORDIC_W){1'b0}}, w_axn[C_CORDIC_W-1:0]});
            r_p3.cy    <= $signed({{(C_CX_W-C_CORDIC_W){1'b0}}, w_yn[C_CORDIC_W-1:0]});
            r_p3.z     <= '0;
            r_p3.side  <= r_p2_side;
        end
    end

    assign w_cd[0] = w_c;

    for (genvar g = 0; g < C_CORDIC_N; g++) begin : g_cordic
        dafp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (C_CORD_IW'(g)),
            .i_d     (w_cd[g]),
            .o_d     (w_cd[g+1])
        );
    end

    always_comb begin
        w_z = w_cd[C_CORDIC_N].z[63] ? 64'd0 : w_cd[C_CORDIC_N].z;
        priority if (w_cd[C_CORDIC_N].side.yzero) begin
            w_ang = w_cd[C_CORDIC_N].side.xneg ? C_PI : 64'd0;
        end else if (w_cd[C_CORDIC_N].side.xneg) begin
            w_ang = C_PI - w_z;
        end else begin
            w_ang = w_z;
        end
        w_rnd = r_f1_ang + (64'(1) << (61 - C_FRAC));
        w_q   = C_TOR_W'(w_rnd[63:62-C_FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_ang  <= w_ang;
            r_f1_tneg <= w_cd[C_CORDIC_N].side.tneg;
            r_f1_deg  <= w_cd[C_CORDIC_N].side.deg;
            r_o_deg   <= r_f1_deg;
            if (r_f1_deg) begin
                r_o_tor <= '0;
            end else if (r_f1_tneg) begin
                r_o_tor <= -$signed(w_q);
            end else begin
                r_o_tor <= $signed(w_q);
            end
        end
    end

    assign o_ang.valid      = r_o_v;
    assign o_ang.torsion    = r_o_tor;
    assign o_ang.degenerate = r_o_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ang.valid && o_ang.degenerate |-> o_ang.torsion == '0)
        else $error("degenerate beat with nonzero torsion");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ang.valid |-> (o_ang.torsion <= $signed(C_TOR_W'(C_PI_Q)))
                     && (o_ang.torsion >= -$signed(C_TOR_W'(C_PI_Q))))
        else $error("torsion outside -pi..pi");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ang.valid && !o_ang.ready |-> !i_pt.ready)
        else $error("input taken while result is held");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ang.valid)
        else $error("result valid after reset");

endmodule
